// ----- hdl/sde_pkg.sv -----
package sde_pkg;

  // Default sizes of the stores
  localparam int NUM_CONTEXTS_DEF  = 16;
  localparam int NUM_RECEIVERS_DEF = 4;
  localparam int NUM_THREADS_DEF   = 16;

  // Field widths
  localparam int CMD_W   = 4;
  localparam int CID_W   = 4;
  localparam int RID_W   = 2;
  localparam int TID_W   = 4;
  localparam int CNT_W   = 32;
  localparam int IMP_W   = 64;
  localparam int EV_W    = 3;
  localparam int STAMP_W = 32;

  localparam logic [CNT_W-1:0] SUBMIT_CEILING = '1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CREATE      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_SUBMIT      = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ACK         = 4'd2;
  localparam logic [CMD_W-1:0] CMD_KILL        = 4'd3;
  localparam logic [CMD_W-1:0] CMD_CANCEL_KILL = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DESTROY_CTX = 4'd5;
  localparam logic [CMD_W-1:0] CMD_ADD_HANDLER = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CANCEL_HNDL = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DESTROY_RCV = 4'd8;

  // Event codes
  localparam logic [EV_W-1:0] EV_DONE        = 3'd0;
  localparam logic [EV_W-1:0] EV_DELIVERED   = 3'd1;
  localparam logic [EV_W-1:0] EV_HNDL_WAIT   = 3'd2;
  localparam logic [EV_W-1:0] EV_HNDL_REFUSE = 3'd3;
  localparam logic [EV_W-1:0] EV_KILL_PEND   = 3'd4;
  localparam logic [EV_W-1:0] EV_KILL_DONE   = 3'd5;
  localparam logic [EV_W-1:0] EV_KILL_FAIL   = 3'd6;

  // Result of one age comparison step
  typedef struct packed {
    logic               take;
    logic [STAMP_W-1:0] age;
  } age_res_t;

endpackage

// ----- hdl/signal_delivery_engine_core.sv -----
// Signal delivery engine. Pulse start while busy is low to issue one command;
// busy stays high until the command has finished. Results come out one per
// cycle on out_valid and cannot be held off; every command ends with a done
// result carrying out_last. A delivery check scans every context and then
// every handler thread through one shared age comparator, one entry a cycle,
// and repeats after each delivery until a pass finds no match. Destroying a
// receiver walks all context slots, one a cycle, pausing for each context
// that it destroys.
module signal_delivery_engine_core #(
  parameter int NUM_CONTEXTS  = sde_pkg::NUM_CONTEXTS_DEF,
  parameter int NUM_RECEIVERS = sde_pkg::NUM_RECEIVERS_DEF,
  parameter int NUM_THREADS   = sde_pkg::NUM_THREADS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [sde_pkg::CMD_W-1:0]   in_cmd,
  input  logic [sde_pkg::CID_W-1:0]   in_context_id,
  input  logic [sde_pkg::RID_W-1:0]   in_receiver_id,
  input  logic [sde_pkg::TID_W-1:0]   in_thread_id,
  input  logic [sde_pkg::CNT_W-1:0]   in_submit_count,
  input  logic [sde_pkg::IMP_W-1:0]   in_imprint,
  output logic                        out_valid,
  output logic [sde_pkg::EV_W-1:0]    out_event_res,
  output logic [sde_pkg::TID_W-1:0]   out_thread_id_out,
  output logic [sde_pkg::IMP_W-1:0]   out_imprint_out,
  output logic [sde_pkg::CNT_W-1:0]   out_count_out,
  output logic                        out_last
);

  localparam int CIW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int TIW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_EXEC   = 10'b00_0000_0010,
    S_DELIV  = 10'b00_0000_0100,
    S_LSCANC = 10'b00_0000_1000,
    S_LSCANH = 10'b00_0001_0000,
    S_LMATCH = 10'b00_0010_0000,
    S_CANCEL = 10'b00_0100_0000,
    S_DESTR  = 10'b00_1000_0000,
    S_RSCAN  = 10'b01_0000_0000,
    S_FIN    = 10'b10_0000_0000
  } state_t;

  state_t state_r;

  // Latched command
  logic [sde_pkg::CMD_W-1:0] cmd_r;
  logic [sde_pkg::CID_W-1:0] cid_r;
  logic [sde_pkg::RID_W-1:0] rid_r;
  logic [sde_pkg::TID_W-1:0] tid_r;
  logic [sde_pkg::CNT_W-1:0] cnt_r;
  logic [sde_pkg::IMP_W-1:0] imp_r;

  // Context store
  logic [NUM_CONTEXTS-1:0]     ctx_valid_r;
  logic [sde_pkg::RID_W-1:0]   ctx_receiver_r   [NUM_CONTEXTS];
  logic [sde_pkg::IMP_W-1:0]   ctx_imprint_r    [NUM_CONTEXTS];
  logic [sde_pkg::CNT_W-1:0]   ctx_pending_r    [NUM_CONTEXTS];
  logic                        ctx_acked_r      [NUM_CONTEXTS];
  logic                        ctx_killed_r     [NUM_CONTEXTS];
  logic                        ctx_has_killer_r [NUM_CONTEXTS];
  logic [sde_pkg::TID_W-1:0]   ctx_killer_r     [NUM_CONTEXTS];
  logic                        ctx_queued_r     [NUM_CONTEXTS];
  logic [sde_pkg::STAMP_W-1:0] ctx_stamp_r      [NUM_CONTEXTS];

  // Thread store
  logic [NUM_THREADS-1:0]      ktv_r;
  logic [sde_pkg::CID_W-1:0]   kt_r             [NUM_THREADS];
  logic [NUM_THREADS-1:0]      hwait_r;
  logic [sde_pkg::RID_W-1:0]   hrecv_r          [NUM_THREADS];
  logic [sde_pkg::STAMP_W-1:0] hstamp_r         [NUM_THREADS];

  logic [sde_pkg::STAMP_W-1:0] oc_r;

  // Sequencer working registers
  logic [CIW:0]                cs_r;
  logic [TIW:0]                hs_r;
  logic [CIW-1:0]              dix_r;
  logic [CIW-1:0]              best_c_r;
  logic [TIW-1:0]              best_h_r;
  logic                        found_c_r;
  logic                        found_h_r;
  logic [sde_pkg::STAMP_W-1:0] best_age_r;
  logic [sde_pkg::RID_W-1:0]   lr_r;
  logic [sde_pkg::CID_W-1:0]   x_r;

  // Output registers
  logic                        out_valid_r;
  logic [sde_pkg::EV_W-1:0]    out_ev_r;
  logic [sde_pkg::TID_W-1:0]   out_tid_r;
  logic [sde_pkg::IMP_W-1:0]   out_imp_r;
  logic [sde_pkg::CNT_W-1:0]   out_cnt_r;
  logic                        out_last_r;

  logic [CIW-1:0] c_idx;
  logic [TIW-1:0] t_idx;
  logic [CIW-1:0] cs_idx;
  logic [TIW-1:0] hs_idx;
  logic [CIW-1:0] x_idx;
  logic           c_in, c_ok, r_ok, t_ok;
  logic [TIW-1:0] kill_idx;
  logic [TIW-1:0] dkill_idx;
  logic           scan_ctx;
  logic           cand_c, cand_h;
  logic [sde_pkg::STAMP_W-1:0] au_stamp;
  sde_pkg::age_res_t           au_res;

  assign c_idx     = CIW'(cid_r);
  assign t_idx     = TIW'(tid_r);
  assign cs_idx    = cs_r[CIW-1:0];
  assign hs_idx    = hs_r[TIW-1:0];
  assign x_idx     = CIW'(x_r);
  assign c_in      = 32'(cid_r) < NUM_CONTEXTS;
  assign c_ok      = c_in && ctx_valid_r[c_idx];
  assign r_ok      = 32'(rid_r) < NUM_RECEIVERS;
  assign t_ok      = 32'(tid_r) < NUM_THREADS;
  assign kill_idx  = TIW'(ctx_killer_r[c_idx]);
  assign dkill_idx = TIW'(ctx_killer_r[dix_r]);

  // Candidates of the current scan step
  assign scan_ctx = (state_r == S_LSCANC);
  assign cand_c   = ctx_valid_r[cs_idx] && ctx_queued_r[cs_idx] &&
                    (ctx_receiver_r[cs_idx] == lr_r);
  assign cand_h   = hwait_r[hs_idx] && (hrecv_r[hs_idx] == lr_r);
  assign au_stamp = scan_ctx ? ctx_stamp_r[cs_idx] : hstamp_r[hs_idx];

  sde_age_unit u_age (
    .counter  (oc_r),
    .stamp    (au_stamp),
    .best_age (best_age_r),
    .found    (scan_ctx ? found_c_r : found_h_r),
    .res      (au_res)
  );

  // Sequencer, stores and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctx_valid_r <= '0;
      ktv_r       <= '0;
      hwait_r     <= '0;
      oc_r        <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_tid_r   <= '0;
      out_imp_r   <= '0;
      out_cnt_r   <= '0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= in_cmd;
            cid_r   <= in_context_id;
            rid_r   <= in_receiver_id;
            tid_r   <= in_thread_id;
            cnt_r   <= in_submit_count;
            imp_r   <= in_imprint;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_FIN;
          unique case (cmd_r)
            sde_pkg::CMD_CREATE: begin
              if (c_in && !ctx_valid_r[c_idx] && r_ok) begin
                ctx_valid_r[c_idx]      <= 1'b1;
                ctx_receiver_r[c_idx]   <= rid_r;
                ctx_imprint_r[c_idx]    <= imp_r;
                ctx_pending_r[c_idx]    <= '0;
                ctx_acked_r[c_idx]      <= 1'b1;
                ctx_killed_r[c_idx]     <= 1'b0;
                ctx_has_killer_r[c_idx] <= 1'b0;
                ctx_killer_r[c_idx]     <= '0;
                ctx_queued_r[c_idx]     <= 1'b0;
              end
            end
            sde_pkg::CMD_SUBMIT: begin
              if (c_ok && !ctx_killed_r[c_idx]) begin
                // Skip the add when it would reach the ceiling
                if (ctx_pending_r[c_idx] < (sde_pkg::SUBMIT_CEILING - cnt_r))
                  ctx_pending_r[c_idx] <= ctx_pending_r[c_idx] + cnt_r;
                if (ctx_acked_r[c_idx])
                  state_r <= S_DELIV;
              end
            end
            sde_pkg::CMD_ACK: begin
              if (c_ok && !ctx_acked_r[c_idx]) begin
                if (!ctx_killed_r[c_idx]) begin
                  ctx_acked_r[c_idx] <= 1'b1;
                  state_r            <= S_DELIV;
                end else if (ctx_has_killer_r[c_idx]) begin
                  ktv_r[kill_idx]         <= 1'b0;
                  ctx_has_killer_r[c_idx] <= 1'b0;
                  out_valid_r             <= 1'b1;
                  out_ev_r                <= sde_pkg::EV_KILL_DONE;
                  out_tid_r               <= ctx_killer_r[c_idx];
                end
              end
            end
            sde_pkg::CMD_KILL: begin
              if (c_ok && t_ok && !ctx_killed_r[c_idx]) begin
                ctx_killed_r[c_idx] <= 1'b1;
                if (!ctx_acked_r[c_idx]) begin
                  ctx_has_killer_r[c_idx] <= 1'b1;
                  ctx_killer_r[c_idx]     <= tid_r;
                  ktv_r[t_idx]            <= 1'b1;
                  kt_r[t_idx]             <= cid_r;
                  out_valid_r             <= 1'b1;
                  out_ev_r                <= sde_pkg::EV_KILL_PEND;
                  out_tid_r               <= tid_r;
                end
              end
            end
            sde_pkg::CMD_CANCEL_KILL: begin
              if (t_ok && ktv_r[t_idx]) begin
                x_r          <= kt_r[t_idx];
                ktv_r[t_idx] <= 1'b0;
                state_r      <= S_CANCEL;
              end
            end
            sde_pkg::CMD_DESTROY_CTX: begin
              if (c_ok) begin
                dix_r   <= c_idx;
                state_r <= S_DESTR;
              end
            end
            sde_pkg::CMD_ADD_HANDLER: begin
              if (t_ok && r_ok) begin
                out_valid_r <= 1'b1;
                out_tid_r   <= tid_r;
                if (hwait_r[t_idx]) begin
                  out_ev_r <= sde_pkg::EV_HNDL_REFUSE;
                end else begin
                  hwait_r[t_idx]  <= 1'b1;
                  hrecv_r[t_idx]  <= rid_r;
                  hstamp_r[t_idx] <= oc_r;
                  oc_r            <= oc_r + 1'b1;
                  out_ev_r        <= sde_pkg::EV_HNDL_WAIT;
                  lr_r            <= rid_r;
                  cs_r            <= '0;
                  found_c_r       <= 1'b0;
                  found_h_r       <= 1'b0;
                  state_r         <= S_LSCANC;
                end
              end
            end
            sde_pkg::CMD_CANCEL_HNDL: begin
              if (t_ok)
                hwait_r[t_idx] <= 1'b0;
            end
            sde_pkg::CMD_DESTROY_RCV: begin
              if (r_ok) begin
                cs_r    <= '0;
                state_r <= S_RSCAN;
              end
            end
            default: begin
            end
          endcase
        end
        S_DELIV: begin
          // Queue the context if it has something to deliver, then match
          if (ctx_pending_r[c_idx] == '0) begin
            state_r <= S_FIN;
          end else begin
            if (!ctx_queued_r[c_idx]) begin
              ctx_queued_r[c_idx] <= 1'b1;
              ctx_stamp_r[c_idx]  <= oc_r;
              oc_r                <= oc_r + 1'b1;
            end
            lr_r      <= ctx_receiver_r[c_idx];
            cs_r      <= '0;
            found_c_r <= 1'b0;
            found_h_r <= 1'b0;
            state_r   <= S_LSCANC;
          end
        end
        S_LSCANC: begin
          // Find the oldest queued context of the receiver
          if (cs_r == (CIW + 1)'(NUM_CONTEXTS)) begin
            hs_r    <= '0;
            state_r <= S_LSCANH;
          end else begin
            if (cand_c && au_res.take) begin
              best_c_r   <= cs_idx;
              best_age_r <= au_res.age;
              found_c_r  <= 1'b1;
            end
            cs_r <= cs_r + 1'b1;
          end
        end
        S_LSCANH: begin
          // Find the oldest waiting handler of the receiver
          if (hs_r == (TIW + 1)'(NUM_THREADS)) begin
            state_r <= S_LMATCH;
          end else begin
            if (cand_h && au_res.take) begin
              best_h_r   <= hs_idx;
              best_age_r <= au_res.age;
              found_h_r  <= 1'b1;
            end
            hs_r <= hs_r + 1'b1;
          end
        end
        S_LMATCH: begin
          if (found_c_r && found_h_r) begin
            hwait_r[best_h_r]        <= 1'b0;
            ctx_pending_r[best_c_r]  <= '0;
            ctx_acked_r[best_c_r]    <= 1'b0;
            ctx_queued_r[best_c_r]   <= 1'b0;
            out_valid_r              <= 1'b1;
            out_ev_r                 <= sde_pkg::EV_DELIVERED;
            out_tid_r                <= sde_pkg::TID_W'(best_h_r);
            out_imp_r                <= ctx_imprint_r[best_c_r];
            out_cnt_r                <= ctx_pending_r[best_c_r];
            cs_r                     <= '0;
            found_c_r                <= 1'b0;
            found_h_r                <= 1'b0;
            state_r                  <= S_LSCANC;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_CANCEL: begin
          // Drop the wait only if this thread is still the target's killer
          if ((32'(x_r) < NUM_CONTEXTS) && ctx_valid_r[x_idx] &&
              ctx_has_killer_r[x_idx] && (ctx_killer_r[x_idx] == tid_r))
            ctx_has_killer_r[x_idx] <= 1'b0;
          state_r <= S_FIN;
        end
        S_DESTR: begin
          if (ctx_has_killer_r[dix_r]) begin
            out_valid_r <= 1'b1;
            out_ev_r    <= sde_pkg::EV_KILL_FAIL;
            out_tid_r   <= ctx_killer_r[dix_r];
            if (ktv_r[dkill_idx] && (CIW'(kt_r[dkill_idx]) == dix_r))
              ktv_r[dkill_idx] <= 1'b0;
          end
          ctx_has_killer_r[dix_r] <= 1'b0;
          ctx_queued_r[dix_r]     <= 1'b0;
          ctx_valid_r[dix_r]      <= 1'b0;
          state_r <= (cmd_r == sde_pkg::CMD_DESTROY_RCV) ? S_RSCAN : S_FIN;
        end
        S_RSCAN: begin
          // Walk the slots in ascending order and destroy the receiver's
          if (cs_r == (CIW + 1)'(NUM_CONTEXTS)) begin
            state_r <= S_FIN;
          end else begin
            if (ctx_valid_r[cs_idx] && (ctx_receiver_r[cs_idx] == rid_r)) begin
              dix_r   <= cs_idx;
              state_r <= S_DESTR;
            end
            cs_r <= cs_r + 1'b1;
          end
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          out_ev_r    <= sde_pkg::EV_DONE;
          out_last_r  <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_event_res     = out_ev_r;
  assign out_thread_id_out = out_tid_r;
  assign out_imprint_out   = out_imp_r;
  assign out_count_out     = out_cnt_r;
  assign out_last          = out_last_r;

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("final done shown while still busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("intermediate result after command finished");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted transaction not followed by busy, quiet cycle");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result directly after final done");

endmodule

// ----- hdl/sde_age_unit.sv -----
module sde_age_unit (
  input  logic [sde_pkg::STAMP_W-1:0] counter,
  input  logic [sde_pkg::STAMP_W-1:0] stamp,
  input  logic [sde_pkg::STAMP_W-1:0] best_age,
  input  logic                        found,
  output sde_pkg::age_res_t           res
);

  logic [sde_pkg::STAMP_W-1:0] age;

  // Age is the wrapping distance from the stamp to the order counter
  assign age      = counter - stamp;
  // Take the first candidate, then only a strictly older one
  assign res.age  = age;
  assign res.take = !found || (age > best_age);

endmodule

// ----- verif/signal_delivery_engine_core_test.sv -----
`timescale 1ns / 1ps

module signal_delivery_engine_core_test;

  localparam int NCTX = sde_pkg::NUM_CONTEXTS_DEF;
  localparam int NRCV = sde_pkg::NUM_RECEIVERS_DEF;
  localparam int NTHR = sde_pkg::NUM_THREADS_DEF;

  // First and last of the command codes that do nothing
  localparam logic [sde_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 4'd9;
  localparam logic [sde_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 4'd15;

  typedef struct packed {
    logic [sde_pkg::EV_W-1:0]  ev;
    logic [sde_pkg::TID_W-1:0] tid;
    logic [sde_pkg::IMP_W-1:0] imp;
    logic [sde_pkg::CNT_W-1:0] cnt;
    logic                      last;
  } event_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [sde_pkg::CMD_W-1:0] in_cmd;
  logic [sde_pkg::CID_W-1:0] in_context_id;
  logic [sde_pkg::RID_W-1:0] in_receiver_id;
  logic [sde_pkg::TID_W-1:0] in_thread_id;
  logic [sde_pkg::CNT_W-1:0] in_submit_count;
  logic [sde_pkg::IMP_W-1:0] in_imprint;
  logic out_valid;
  logic [sde_pkg::EV_W-1:0] out_event_res;
  logic [sde_pkg::TID_W-1:0] out_thread_id_out;
  logic [sde_pkg::IMP_W-1:0] out_imprint_out;
  logic [sde_pkg::CNT_W-1:0] out_count_out;
  logic out_last;

  signal_delivery_engine_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_context_id(in_context_id), .in_receiver_id(in_receiver_id),
    .in_thread_id(in_thread_id), .in_submit_count(in_submit_count),
    .in_imprint(in_imprint), .out_valid(out_valid), .out_event_res(out_event_res),
    .out_thread_id_out(out_thread_id_out), .out_imprint_out(out_imprint_out),
    .out_count_out(out_count_out), .out_last(out_last)
  );

  // Shadow state of the engine
  logic                        sh_valid [NCTX];
  logic [sde_pkg::RID_W-1:0]   sh_rcv [NCTX];
  logic [sde_pkg::IMP_W-1:0]   sh_imp [NCTX];
  logic [sde_pkg::CNT_W-1:0]   sh_pend [NCTX];
  logic                        sh_acked [NCTX];
  logic                        sh_killed [NCTX];
  logic                        sh_has_killer [NCTX];
  logic [sde_pkg::TID_W-1:0]   sh_killer [NCTX];
  logic                        sh_queued [NCTX];
  logic [sde_pkg::STAMP_W-1:0] sh_cstamp [NCTX];
  logic                        kt_valid [NTHR];
  logic [sde_pkg::CID_W-1:0]   kt_ctx [NTHR];
  logic                        hd_wait [NTHR];
  logic [sde_pkg::RID_W-1:0]   hd_rcv [NTHR];
  logic [sde_pkg::STAMP_W-1:0] hd_stamp [NTHR];
  logic [sde_pkg::STAMP_W-1:0] order_cnt;

  event_t expected_events[$];
  int errors = 0;
  int n_trans = 0;
  int n_events = 0;
  int n_deliv = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void push_event(logic [sde_pkg::EV_W-1:0] ev,
                                     logic [sde_pkg::TID_W-1:0] tid,
                                     logic [sde_pkg::IMP_W-1:0] imp,
                                     logic [sde_pkg::CNT_W-1:0] cnt,
                                     logic last);
    event_t e;
    e = '{ev: ev, tid: tid, imp: imp, cnt: cnt, last: last};
    expected_events.push_back(e);
  endfunction

  // Pair the oldest queued context with the oldest waiting handler, repeatedly
  function automatic void match_receiver(logic [sde_pkg::RID_W-1:0] r);
    int c;
    int h;
    logic [sde_pkg::STAMP_W-1:0] best;
    logic [sde_pkg::STAMP_W-1:0] age;
    forever begin
      c = -1;
      h = -1;
      best = '0;
      for (int i = 0; i < NCTX; i++) begin
        if (sh_valid[i] && sh_queued[i] && sh_rcv[i] == r) begin
          age = order_cnt - sh_cstamp[i];
          if (c < 0 || age > best) begin c = i; best = age; end
        end
      end
      for (int t = 0; t < NTHR; t++) begin
        if (hd_wait[t] && hd_rcv[t] == r) begin
          age = order_cnt - hd_stamp[t];
          if (h < 0 || age > best) begin h = t; best = age; end
        end
      end
      if (c < 0 || h < 0) return;
      hd_wait[h] = 1'b0;
      push_event(sde_pkg::EV_DELIVERED, sde_pkg::TID_W'(h), sh_imp[c], sh_pend[c], 1'b0);
      sh_pend[c] = '0;
      sh_acked[c] = 1'b0;
      sh_queued[c] = 1'b0;
    end
  endfunction

  function automatic void offer_context(int c);
    if (sh_pend[c] == '0) return;
    if (!sh_queued[c]) begin
      sh_queued[c] = 1'b1;
      sh_cstamp[c] = order_cnt;
      order_cnt++;
    end
    match_receiver(sh_rcv[c]);
  endfunction

  function automatic void drop_context(int c);
    logic [sde_pkg::TID_W-1:0] k;
    if (sh_has_killer[c]) begin
      k = sh_killer[c];
      push_event(sde_pkg::EV_KILL_FAIL, k, '0, '0, 1'b0);
      if (kt_valid[k] && kt_ctx[k] == c) kt_valid[k] = 1'b0;
    end
    sh_has_killer[c] = 1'b0;
    sh_queued[c] = 1'b0;
    sh_valid[c] = 1'b0;
  endfunction

  // Work out the events one command causes
  function automatic void predict_events(logic [sde_pkg::CMD_W-1:0] cmd,
                                         logic [sde_pkg::CID_W-1:0] c,
                                         logic [sde_pkg::RID_W-1:0] r,
                                         logic [sde_pkg::TID_W-1:0] t,
                                         logic [sde_pkg::CNT_W-1:0] n,
                                         logic [sde_pkg::IMP_W-1:0] imp);
    logic [sde_pkg::TID_W-1:0] k;
    logic [sde_pkg::CID_W-1:0] x;
    case (cmd)
      sde_pkg::CMD_CREATE: begin
        if (!sh_valid[c]) begin
          sh_valid[c] = 1'b1;
          sh_rcv[c] = r;
          sh_imp[c] = imp;
          sh_pend[c] = '0;
          sh_acked[c] = 1'b1;
          sh_killed[c] = 1'b0;
          sh_has_killer[c] = 1'b0;
          sh_killer[c] = '0;
          sh_queued[c] = 1'b0;
        end
      end
      sde_pkg::CMD_SUBMIT: begin
        if (sh_valid[c] && !sh_killed[c]) begin
          if (sh_pend[c] < sde_pkg::SUBMIT_CEILING - n) sh_pend[c] = sh_pend[c] + n;
          if (sh_acked[c]) offer_context(c);
        end
      end
      sde_pkg::CMD_ACK: begin
        if (sh_valid[c] && !sh_acked[c]) begin
          if (!sh_killed[c]) begin
            sh_acked[c] = 1'b1;
            offer_context(c);
          end else if (sh_has_killer[c]) begin
            k = sh_killer[c];
            kt_valid[k] = 1'b0;
            push_event(sde_pkg::EV_KILL_DONE, k, '0, '0, 1'b0);
            sh_has_killer[c] = 1'b0;
          end
        end
      end
      sde_pkg::CMD_KILL: begin
        if (sh_valid[c] && !sh_killed[c]) begin
          sh_killed[c] = 1'b1;
          if (!sh_acked[c]) begin
            sh_has_killer[c] = 1'b1;
            sh_killer[c] = t;
            kt_valid[t] = 1'b1;
            kt_ctx[t] = c;
            push_event(sde_pkg::EV_KILL_PEND, t, '0, '0, 1'b0);
          end
        end
      end
      sde_pkg::CMD_CANCEL_KILL: begin
        if (kt_valid[t]) begin
          x = kt_ctx[t];
          if (sh_valid[x] && sh_has_killer[x] && sh_killer[x] == t)
            sh_has_killer[x] = 1'b0;
          kt_valid[t] = 1'b0;
        end
      end
      sde_pkg::CMD_DESTROY_CTX: begin
        if (sh_valid[c]) drop_context(c);
      end
      sde_pkg::CMD_ADD_HANDLER: begin
        if (hd_wait[t]) begin
          push_event(sde_pkg::EV_HNDL_REFUSE, t, '0, '0, 1'b0);
        end else begin
          hd_wait[t] = 1'b1;
          hd_rcv[t] = r;
          hd_stamp[t] = order_cnt;
          order_cnt++;
          push_event(sde_pkg::EV_HNDL_WAIT, t, '0, '0, 1'b0);
          match_receiver(r);
        end
      end
      sde_pkg::CMD_CANCEL_HNDL: hd_wait[t] = 1'b0;
      sde_pkg::CMD_DESTROY_RCV: begin
        for (int i = 0; i < NCTX; i++)
          if (sh_valid[i] && sh_rcv[i] == r) drop_context(i);
      end
      default: ;
    endcase
    push_event(sde_pkg::EV_DONE, '0, '0, '0, 1'b1);
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Compare each result against the oldest outstanding expectation
  always @(posedge clk) begin
    event_t e;
    if (rst_n && out_valid) begin
      n_events++;
      if (out_event_res == sde_pkg::EV_DELIVERED) n_deliv++;
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event %0d", out_event_res));
      end else begin
        e = expected_events.pop_front();
        if (out_event_res !== e.ev || out_thread_id_out !== e.tid ||
            out_imprint_out !== e.imp || out_count_out !== e.cnt || out_last !== e.last)
          report_mismatch($sformatf("got ev%0d t%0d i%h c%h l%b, want ev%0d t%0d i%h c%h l%b",
            out_event_res, out_thread_id_out, out_imprint_out, out_count_out, out_last,
            e.ev, e.tid, e.imp, e.cnt, e.last));
      end
    end
  end

  // Issue one transaction after a random gap; start is left high for the next one
  task automatic send(logic [sde_pkg::CMD_W-1:0] cmd, logic [sde_pkg::CID_W-1:0] c,
                      logic [sde_pkg::RID_W-1:0] r, logic [sde_pkg::TID_W-1:0] t,
                      logic [sde_pkg::CNT_W-1:0] n, logic [sde_pkg::IMP_W-1:0] imp);
    int p;
    int gap;
    p = $urandom_range(99);
    gap = (p < 55) ? 0 : (p < 93) ? $urandom_range(3, 1) : $urandom_range(40, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_context_id <= c;
    in_receiver_id <= r;
    in_thread_id <= t;
    in_submit_count <= n;
    in_imprint <= imp;
    do @(posedge clk); while (busy);
    predict_events(cmd, c, r, t, n, imp);
    n_trans++;
  endtask

  function automatic logic [sde_pkg::IMP_W-1:0] rand_imp();
    return {$urandom, $urandom};
  endfunction

  task automatic test_lifecycle();
    send(sde_pkg::CMD_CREATE, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send(sde_pkg::CMD_CREATE, 15, 3, 0, 0, 64'h0);
    send(sde_pkg::CMD_CREATE, 0, 1, 0, 0, 64'h1234);        // used slot stays
    send(sde_pkg::CMD_SUBMIT, 0, 0, 0, 32'd3, 0);
    send(sde_pkg::CMD_ADD_HANDLER, 0, 0, 15, 0, 0);         // delivers at once
    send(sde_pkg::CMD_ADD_HANDLER, 0, 0, 15, 0, 0);
    send(sde_pkg::CMD_ADD_HANDLER, 0, 0, 15, 0, 0);         // refused
    send(sde_pkg::CMD_SUBMIT, 0, 0, 0, 32'd2, 0);
    send(sde_pkg::CMD_ACK, 0, 0, 0, 0, 0);                  // delivers to thread 15
    send(sde_pkg::CMD_SUBMIT, 15, 0, 0, 32'hFFFF_FFFE, 0);  // one below the ceiling: added
    send(sde_pkg::CMD_SUBMIT, 15, 0, 0, 32'hFFFF_FFFD, 0);
    send(sde_pkg::CMD_SUBMIT, 15, 0, 0, 32'd1, 0);
    send(sde_pkg::CMD_ADD_HANDLER, 0, 3, 0, 0, 0);
    send(sde_pkg::CMD_CANCEL_HNDL, 0, 0, 0, 0, 0);
  endtask

  task automatic test_kill();
    send(sde_pkg::CMD_KILL, 0, 0, 4, 0, 0);                 // unacked: kill pending
    send(sde_pkg::CMD_SUBMIT, 0, 0, 0, 32'd9, 0);           // dropped on a killed context
    send(sde_pkg::CMD_ACK, 0, 0, 0, 0, 0);                  // kill done
    send(sde_pkg::CMD_CREATE, 5, 2, 0, 0, rand_imp());
    send(sde_pkg::CMD_CREATE, 6, 2, 0, 0, rand_imp());
    send(sde_pkg::CMD_ADD_HANDLER, 0, 2, 7, 0, 0);
    send(sde_pkg::CMD_ADD_HANDLER, 0, 2, 8, 0, 0);
    send(sde_pkg::CMD_SUBMIT, 5, 0, 0, 32'd1, 0);
    send(sde_pkg::CMD_SUBMIT, 6, 0, 0, 32'd1, 0);
    send(sde_pkg::CMD_KILL, 5, 0, 9, 0, 0);
    send(sde_pkg::CMD_KILL, 6, 0, 9, 0, 0);                 // same thread retargets
    send(sde_pkg::CMD_CANCEL_KILL, 0, 0, 9, 0, 0);
    send(sde_pkg::CMD_DESTROY_RCV, 0, 2, 0, 0, 0);          // context 5 reports kill failed
    send(sde_pkg::CMD_DESTROY_CTX, 15, 0, 0, 0, 0);
    send(sde_pkg::CMD_DESTROY_CTX, 15, 0, 0, 0, 0);         // free slot
    send(CMD_UNUSED_FIRST, 0, 0, 0, 0, 0);
    send(CMD_UNUSED_LAST, 15, 3, 15, '1, '1);
  endtask

  task automatic test_random(int count);
    int w;
    logic [sde_pkg::CMD_W-1:0] cmd;
    logic [sde_pkg::CNT_W-1:0] n;
    logic [sde_pkg::CID_W-1:0] c;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(99);
      if (w < 14) cmd = sde_pkg::CMD_CREATE;
      else if (w < 34) cmd = sde_pkg::CMD_SUBMIT;
      else if (w < 50) cmd = sde_pkg::CMD_ACK;
      else if (w < 58) cmd = sde_pkg::CMD_KILL;
      else if (w < 62) cmd = sde_pkg::CMD_CANCEL_KILL;
      else if (w < 67) cmd = sde_pkg::CMD_DESTROY_CTX;
      else if (w < 88) cmd = sde_pkg::CMD_ADD_HANDLER;
      else if (w < 93) cmd = sde_pkg::CMD_CANCEL_HNDL;
      else if (w < 96) cmd = sde_pkg::CMD_DESTROY_RCV;
      else cmd = sde_pkg::CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
      w = $urandom_range(9);
      n = (w < 5) ? $urandom_range(4, 1) : (w < 6) ? '0 :
          (w < 8) ? 32'hFFFF_FFFF - $urandom_range(3) : $urandom;
      c = ($urandom_range(3) == 0) ? sde_pkg::CID_W'($urandom_range(NCTX - 1)) :
                                     sde_pkg::CID_W'($urandom_range(5));
      send(cmd, c, sde_pkg::RID_W'($urandom_range(NRCV - 1)),
           sde_pkg::TID_W'($urandom_range(NTHR - 1)), n, rand_imp());
    end
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = '0;
    in_context_id = '0;
    in_receiver_id = '0;
    in_thread_id = '0;
    in_submit_count = '0;
    in_imprint = '0;
    for (int i = 0; i < NCTX; i++) begin
      sh_valid[i] = 1'b0;
      sh_has_killer[i] = 1'b0;
      sh_queued[i] = 1'b0;
    end
    for (int i = 0; i < NTHR; i++) begin
      kt_valid[i] = 1'b0;
      hd_wait[i] = 1'b0;
    end
    order_cnt = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_lifecycle();
    test_kill();
    test_random(320);
    start <= 1'b0;

    // Drain outstanding events, then let the bench idle before reporting
    waited = 0;
    while ((expected_events.size() != 0 || busy) && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    $display("Ran %0d transactions: %0d events checked, %0d deliveries, %0d mismatches",
             n_trans, n_events, n_deliv, errors);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
